@@ hw/rtl/ccfr_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the COBS frame receiver.
// No dependencies; imported by ccfr_deframer and the top level.
package ccfr_pkg;

	localparam int RX_BUF_BYTES_DEF = 256;
	localparam int MAX_PAYLOAD_DEF  = 128;

	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [7:0]  COBS_FULL = 8'hFF;
	localparam logic [7:0]  FRAME_END = 8'h00;

	localparam logic OP_RX   = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_TAKEN    = 3'd0,
		ST_OVERFLOW = 3'd1,
		ST_ACCEPT   = 3'd2,
		ST_BAD_LEN  = 3'd3,
		ST_BAD_CRC  = 3'd4,
		ST_NO_FRAME = 3'd5,
		ST_READ_OK  = 3'd6
	} status_t;

	// result of one beat, as seen after that beat's state update
	typedef struct packed {
		status_t    status;
		logic       frame_ready;
		logic [7:0] message_id;
		logic [7:0] payload_length;
		logic       rd_hit;
	} res_t;

	// reflected CRC-16, one byte, bit steps unrolled
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/ccfr_payload_ram.sv @@
// Double-banked payload store: one write port, one read port, registered read data.
// Depends on nothing; the bank select is the top address bit.
module ccfr_payload_ram #(
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/ccfr_deframer.sv @@
// COBS decode, header/CRC tracking, frame checks and stored-frame registers.
// Uses ccfr_pkg; drives the write and read ports of ccfr_payload_ram.
module ccfr_deframer #(
	parameter int RX_BUF_BYTES = ccfr_pkg::RX_BUF_BYTES_DEF,
	parameter int MAX_PAYLOAD  = ccfr_pkg::MAX_PAYLOAD_DEF,
	parameter int ADDR_W       = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              op,
	input  logic [7:0]        rx_byte,
	input  logic [6:0]        rd_offset,
	input  logic              release_req,
	output ccfr_pkg::res_t    res,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [7:0]        wr_data,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr
);
	import ccfr_pkg::*;

	localparam int PW = ADDR_W - 1;
	localparam int RW = $clog2(RX_BUF_BYTES + 1);
	localparam int LW = $clog2(MAX_PAYLOAD + 1);
	localparam int EW = ((RW > 16) ? RW : 16) + 2;

	logic [RW-1:0] raw_cnt_q,  raw_cnt_n;
	logic [RW-1:0] dec_cnt_q,  dec_cnt_n;
	logic [7:0]    blk_rem_q,  blk_rem_n;
	logic          full_q,     full_n;
	logic          owed_q,     owed_n;
	logic [15:0]   crc_q,      crc_n;
	logic [15:0]   hdr_len_q,  hdr_len_n;
	logic [7:0]    hdr_id_q,   hdr_id_n;
	logic [15:0]   rx_crc_q,   rx_crc_n;
	logic          bank_q,     bank_n;
	logic          has_q,      has_n;
	logic [7:0]    sid_q,      sid_n;
	logic [LW-1:0] slen_q,     slen_n;

	logic          dec_en;
	logic [7:0]    dec_byte;
	logic          restart;
	logic          trunc;
	logic [EW-1:0] k_e, len_e, dlen_e, pos_e, idx_e;

	assign k_e   = EW'(dec_cnt_q);
	assign len_e = EW'(hdr_len_q);
	assign pos_e = k_e - EW'(3);
	assign idx_e = EW'(rd_offset);

	always_comb begin
		raw_cnt_n = raw_cnt_q;
		dec_cnt_n = dec_cnt_q;
		blk_rem_n = blk_rem_q;
		full_n    = full_q;
		owed_n    = owed_q;
		crc_n     = crc_q;
		hdr_len_n = hdr_len_q;
		hdr_id_n  = hdr_id_q;
		rx_crc_n  = rx_crc_q;
		bank_n    = bank_q;
		has_n     = has_q;
		sid_n     = sid_q;
		slen_n    = slen_q;
		dec_en    = 1'b0;
		dec_byte  = rx_byte;
		restart   = 1'b0;
		trunc     = 1'b0;
		dlen_e    = '0;
		wr_en     = 1'b0;
		wr_addr   = {~bank_q, pos_e[PW-1:0]};
		rd_en     = 1'b0;
		rd_addr   = {bank_q, idx_e[PW-1:0]};
		res.status = ST_TAKEN;
		res.rd_hit = 1'b0;

		if (fire) begin
			if (op == OP_RX) begin
				if (rx_byte == FRAME_END) begin
					restart = 1'b1;
					trunc   = (blk_rem_q != 8'd0);
					dlen_e  = trunc ? '0 : k_e;
					if (dlen_e < EW'(3) || len_e + EW'(5) > dlen_e
							|| len_e > EW'(MAX_PAYLOAD)) begin
						res.status = ST_BAD_LEN;
					end else if (rx_crc_q != crc_q) begin
						res.status = ST_BAD_CRC;
					end else begin
						res.status = ST_ACCEPT;
						bank_n = ~bank_q;
						sid_n  = hdr_id_q;
						slen_n = LW'(hdr_len_q);
						has_n  = 1'b1;
					end
				end else if (raw_cnt_q < RW'(RX_BUF_BYTES)) begin
					raw_cnt_n = raw_cnt_q + RW'(1);
					if (blk_rem_q == 8'd0) begin
						// code byte: emit the zero owed by the previous short block
						dec_en    = owed_q;
						dec_byte  = 8'h00;
						blk_rem_n = rx_byte - 8'd1;
						full_n    = (rx_byte == COBS_FULL);
						owed_n    = (rx_byte == 8'd1);
					end else begin
						dec_en    = 1'b1;
						blk_rem_n = blk_rem_q - 8'd1;
						if (blk_rem_q == 8'd1) begin
							owed_n = ~full_q;
						end
					end
				end else begin
					res.status = ST_OVERFLOW;
					restart    = 1'b1;
				end
			end else if (!has_q) begin
				res.status = ST_NO_FRAME;
			end else begin
				res.status = ST_READ_OK;
				rd_en      = 1'b1;
				res.rd_hit = (idx_e < EW'(slen_q)) && (idx_e < EW'(MAX_PAYLOAD));
				if (release_req) begin
					has_n = 1'b0;
				end
			end
		end

		// one decoded byte at most per beat
		if (dec_en) begin
			dec_cnt_n = dec_cnt_q + RW'(1);
			if (k_e < EW'(3)) begin
				crc_n = crc16_byte(crc_q, dec_byte);
				if (k_e == EW'(0)) begin
					hdr_id_n = dec_byte;
				end else if (k_e == EW'(1)) begin
					hdr_len_n = {hdr_len_q[15:8], dec_byte};
				end else begin
					hdr_len_n = {dec_byte, hdr_len_q[7:0]};
				end
			end else if (k_e < len_e + EW'(3)) begin
				crc_n = crc16_byte(crc_q, dec_byte);
				wr_en = (pos_e < EW'(MAX_PAYLOAD));
			end else if (k_e == len_e + EW'(3)) begin
				rx_crc_n = {rx_crc_q[15:8], dec_byte};
			end else if (k_e == len_e + EW'(4)) begin
				rx_crc_n = {dec_byte, rx_crc_q[7:0]};
			end
		end

		if (restart) begin
			raw_cnt_n = '0;
			dec_cnt_n = '0;
			blk_rem_n = 8'd0;
			full_n    = 1'b0;
			owed_n    = 1'b0;
			crc_n     = CRC_INIT;
			hdr_len_n = 16'd0;
			hdr_id_n  = 8'd0;
			rx_crc_n  = 16'd0;
		end

		res.frame_ready    = has_n;
		res.message_id     = sid_n;
		res.payload_length = 8'(slen_n);
	end

	assign wr_data = dec_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_cnt_q <= '0;
			dec_cnt_q <= '0;
			blk_rem_q <= 8'd0;
			full_q    <= 1'b0;
			owed_q    <= 1'b0;
			crc_q     <= CRC_INIT;
			hdr_len_q <= 16'd0;
			hdr_id_q  <= 8'd0;
			rx_crc_q  <= 16'd0;
			bank_q    <= 1'b0;
			has_q     <= 1'b0;
			sid_q     <= 8'd0;
			slen_q    <= '0;
		end else begin
			raw_cnt_q <= raw_cnt_n;
			dec_cnt_q <= dec_cnt_n;
			blk_rem_q <= blk_rem_n;
			full_q    <= full_n;
			owed_q    <= owed_n;
			crc_q     <= crc_n;
			hdr_len_q <= hdr_len_n;
			hdr_id_q  <= hdr_id_n;
			rx_crc_q  <= rx_crc_n;
			bank_q    <= bank_n;
			has_q     <= has_n;
			sid_q     <= sid_n;
			slen_q    <= slen_n;
		end
	end

endmodule

@@ hw/rtl/cobs_crc16_frame_receiver.sv @@
// Top level of the COBS frame receiver with CRC-16 check and latest-frame store.
// Uses ccfr_pkg, ccfr_deframer and ccfr_payload_ram.
//
// Every input beat gives exactly one result beat, in the cycle after it is accepted, through a
// single output register; a new beat is taken every cycle while the output is empty or being
// drained, so the sustained rate is one beat per clock. A receive beat (op 0) decodes one link
// byte and writes any decoded payload byte into the spare bank of the payload RAM; a read beat
// (op 1) reads the active bank through the RAM's registered read port. A good frame swaps banks
// on its closing zero byte, so reads never see a frame still being received. The payload RAM is
// not cleared after reset; only bytes of an accepted frame are ever read back. Status codes:
// 0 taken, 1 overflow drop, 2 frame accepted, 3 bad length, 4 bad CRC, 5 no frame, 6 read ok.
module cobs_crc16_frame_receiver #(
	parameter int RX_BUF_BYTES = ccfr_pkg::RX_BUF_BYTES_DEF,
	parameter int MAX_PAYLOAD  = ccfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // rx_byte[7:0], rd_offset[14:8], release_req[15]
	input  logic [0:0]  s_tuser,  // op[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // frame_ready[0], message_id[8:1], payload_length[16:9],
	                              // data_byte[24:17], zero[31:25]
	output logic [2:0]  m_tuser   // status[2:0]
);
	import ccfr_pkg::*;

	localparam int PW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int ADDR_W = PW + 1;

	logic              fire;
	res_t              res;
	res_t              res_s2;
	logic              m_valid_q;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	logic [7:0]        data_byte;

	assign s_tready = ~m_valid_q | m_tready;
	assign fire     = s_tvalid & s_tready;

	ccfr_deframer #(
		.RX_BUF_BYTES (RX_BUF_BYTES),
		.MAX_PAYLOAD  (MAX_PAYLOAD),
		.ADDR_W       (ADDR_W)
	) u_deframer (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.op          (s_tuser[0]),
		.rx_byte     (s_tdata[7:0]),
		.rd_offset   (s_tdata[14:8]),
		.release_req (s_tdata[15]),
		.res         (res),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr)
	);

	// read port only advances on an accepted beat, so rd_data holds while stalled
	ccfr_payload_ram #(
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign data_byte = res_s2.rd_hit ? rd_data : 8'h00;
	assign m_tvalid  = m_valid_q;
	assign m_tuser   = res_s2.status;
	assign m_tdata   = {7'd0, data_byte, res_s2.payload_length, res_s2.message_id,
	                    res_s2.frame_ready};

	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("accepted beat produced no result");

	a_accept_sets_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_ACCEPT) |-> m_tdata[0])
		else $error("frame accepted without frame_ready");

	a_no_frame_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_NO_FRAME) |-> !m_tdata[0])
		else $error("no-frame status with frame_ready set");

	a_data_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_READ_OK) |-> (m_tdata[24:17] == 8'h00))
		else $error("data byte nonzero outside a read");

endmodule
